>>> hdl/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// shared types and constants of the ordered list engine: word formats,
// opcodes, controller states and the controller/datapath command bundle
// ----------------------------------------------------------------------------
package ole_pkg;

   // list storage
   localparam int DEPTH = 64;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // store address
   localparam int LW    = $clog2(DEPTH + 1);                 // length, 0..DEPTH

   // operation codes of a request word
   typedef enum logic [1:0] {
      FUNC_INSERT  = 2'd0,
      FUNC_LIST    = 2'd1,
      FUNC_DELETE  = 2'd2,
      FUNC_REVERSE = 2'd3
   } ole_func_type;

   // status codes of a response word
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FAIL = 2'd1,
      ST_ITEM = 2'd2
   } ole_status_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         position;
      logic signed [31:0] value;
   } ole_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic               last;
   } ole_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_LAST,
      S_INS_WRITE,
      S_DEL_SHIFT,
      S_DEL_LAST,
      S_REV_READ,
      S_REV_WLO,
      S_REV_WHI,
      S_LIST_READ,
      S_LIST_SEND,
      S_RESULT
   } ole_state_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_LEN_M1,
      CUR_POS_P1,
      CUR_ZERO,
      CUR_INC,
      CUR_DEC
   } ole_cur_op_type;

   typedef enum logic [1:0] {
      HI_HOLD,
      HI_LEN_M1,
      HI_DEC
   } ole_hi_op_type;

   typedef enum logic [1:0] {
      LEN_HOLD,
      LEN_INC,
      LEN_DEC
   } ole_len_op_type;

   typedef enum logic [2:0] {
      WA_CUR_P2,
      WA_CUR_P1,
      WA_CUR_M2,
      WA_CUR_M1,
      WA_CUR,
      WA_HI,
      WA_POS
   } ole_wa_sel_type;

   typedef enum logic [1:0] {
      WD_RDA,
      WD_RDB,
      WD_VAL
   } ole_wd_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic           load_req;
      ole_cur_op_type cur_op;
      ole_hi_op_type  hi_op;
      ole_len_op_type len_op;
      logic           rd_en;
      logic           wr_en;
      ole_wa_sel_type wa_sel;
      ole_wd_sel_type wd_sel;
      logic           out_load;
      ole_status_type out_status;
   } ole_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic ins_ok;
      logic ins_append;
      logic del_ok;
      logic del_none;
      logic len_zero;
      logic len_lt2;
      logic cur_eq_pos;
      logic cur_eq_len;
      logic cur_last;
      logic rev_more;
      logic out_free;
   } ole_stat_type;

endpackage

>>> hdl/ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// bounded ordered list of signed 32-bit values with insert, delete,
// reverse and in-order listing, built as a sequencer plus a store datapath
// ----------------------------------------------------------------------------
//
//   channel  ports                        direction  word
//   req      req_valid/req_ready/req_data in         func, position, value
//   rsp      rsp_valid/rsp_ready/rsp_data out        status, element, last
//
// one request word is worked at a time; req_ready is high only when idle
// insert and delete shift the list tail one element per step, reverse swaps
//   pairs from both ends, listing reads and sends one element at a time
// the store is a single-write, dual-read memory with registered read data;
//   its contents are undefined after reset and need no clearing pass
// reset (synchronous) clears the length, the sequencer and rsp_valid
// the response register lets the next word start while a response waits;
//   a new response stalls in its send state until the old one is taken
//
module ordered_list_engine_core
   import ole_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_valid,
   output logic        req_ready,
   input  ole_req_type req_data,
   // response words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ole_rsp_type rsp_data
);

   // command bundle from sequencer, flags back from datapath
   ole_cmd_type  cmd;
   ole_stat_type stat;

   // sequencer: decodes the opcode and walks shifts, swaps and listings
   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: list store, length, cursors and response register
   ole_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/ole_dp.sv
// ----------------------------------------------------------------------------
// ole_dp
// list store, length and cursors, compare flags and the response register
// ----------------------------------------------------------------------------
module ole_dp
   import ole_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ole_req_type  req_data,
   input  ole_cmd_type  cmd,
   output ole_stat_type stat,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output ole_rsp_type  rsp_data
);

   logic [31:0]   mem_ram [DEPTH];
   logic [31:0]   rd_a_ff;
   logic [31:0]   rd_b_ff;

   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] cursor_ff, cursor_in;
   logic [LW-1:0] hi_ff, hi_in;
   logic [7:0]    pos_ff;
   logic [31:0]   val_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   ole_rsp_type   rsp_data_ff, rsp_data_in;

   logic [LW:0]   cur_ext;
   logic [LW:0]   addr_wide;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [7:0]    len8;

   assign cur_ext = {1'b0, cursor_ff};
   assign len8    = 8'(len_ff);

   // write address and data
   always_comb begin
      unique case (cmd.wa_sel)
         WA_CUR_P2: addr_wide = cur_ext + (LW+1)'(2);
         WA_CUR_P1: addr_wide = cur_ext + (LW+1)'(1);
         WA_CUR_M2: addr_wide = cur_ext - (LW+1)'(2);
         WA_CUR_M1: addr_wide = cur_ext - (LW+1)'(1);
         WA_CUR:    addr_wide = cur_ext;
         WA_HI:     addr_wide = {1'b0, hi_ff};
         WA_POS:    addr_wide = (LW+1)'(pos_ff);
         default:   addr_wide = cur_ext;
      endcase
      wr_addr = addr_wide[AW-1:0];
      unique case (cmd.wd_sel)
         WD_RDA:  wr_data = rd_a_ff;
         WD_RDB:  wr_data = rd_b_ff;
         WD_VAL:  wr_data = val_ff;
         default: wr_data = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ram[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_a_ff <= mem_ram[cursor_ff[AW-1:0]];
         rd_b_ff <= mem_ram[hi_ff[AW-1:0]];
      end
   end

   // length and cursors
   always_comb begin
      unique case (cmd.len_op)
         LEN_INC: len_in = len_ff + LW'(1);
         LEN_DEC: len_in = len_ff - LW'(1);
         default: len_in = len_ff;
      endcase
      unique case (cmd.cur_op)
         CUR_LEN_M1: cursor_in = len_ff - LW'(1);
         CUR_POS_P1: cursor_in = LW'(req_data.position) + LW'(1);
         CUR_ZERO:   cursor_in = '0;
         CUR_INC:    cursor_in = cursor_ff + LW'(1);
         CUR_DEC:    cursor_in = cursor_ff - LW'(1);
         default:    cursor_in = cursor_ff;
      endcase
      unique case (cmd.hi_op)
         HI_LEN_M1: hi_in = len_ff - LW'(1);
         HI_DEC:    hi_in = hi_ff - LW'(1);
         default:   hi_in = hi_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      hi_ff     <= hi_in;
      if (cmd.load_req) begin
         pos_ff <= req_data.position;
         val_ff <= req_data.value;
      end
   end

   // response register
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_data_in.status = cmd.out_status;
         if (cmd.out_status == ST_ITEM) begin
            rsp_data_in.element = rd_a_ff;
            rsp_data_in.last    = stat.cur_last;
         end else begin
            rsp_data_in.element = '0;
            rsp_data_in.last    = 1'b1;
         end
      end
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // flags for the controller
   always_comb begin
      stat.ins_ok     = (len_ff != LW'(DEPTH)) && (req_data.position <= len8);
      stat.ins_append = req_data.position == len8;
      stat.del_ok     = req_data.position < len8;
      stat.del_none   = (9'(req_data.position) + 9'd1) == 9'(len_ff);
      stat.len_zero   = len_ff == '0;
      stat.len_lt2    = len_ff < LW'(2);
      stat.cur_eq_pos = 8'(cursor_ff) == pos_ff;
      stat.cur_eq_len = cursor_ff == len_ff;
      stat.cur_last   = (cur_ext + (LW+1)'(1)) == {1'b0, len_ff};
      stat.rev_more   = (cur_ext + (LW+1)'(2)) < {1'b0, hi_ff};
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

>>> hdl/ole_ctrl.sv
// ----------------------------------------------------------------------------
// ole_ctrl
// operation sequencer: decodes a request word and steps the datapath
// through shifts, swaps and listings
// ----------------------------------------------------------------------------
module ole_ctrl
   import ole_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ole_req_type  req_data,
   input  ole_stat_type stat,
   output ole_cmd_type  cmd
);

   ole_state_type state_ff, state_in;
   logic          first_ff, first_in;
   logic          ok_ff, ok_in;
   logic          accept;

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      first_in = 1'b0;
      ok_in    = ok_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.func)
                  FUNC_INSERT: begin
                     ok_in = stat.ins_ok;
                     if (!stat.ins_ok) begin
                        state_in = S_RESULT;
                     end else if (stat.ins_append) begin
                        state_in = S_INS_WRITE;
                     end else begin
                        state_in = S_INS_SHIFT;
                        first_in = 1'b1;
                     end
                  end
                  FUNC_DELETE: begin
                     ok_in = stat.del_ok;
                     if (!stat.del_ok || stat.del_none) begin
                        state_in = S_RESULT;
                     end else begin
                        state_in = S_DEL_SHIFT;
                        first_in = 1'b1;
                     end
                  end
                  FUNC_LIST: begin
                     if (!stat.len_zero) begin
                        state_in = S_LIST_READ;
                     end
                  end
                  FUNC_REVERSE: begin
                     if (!stat.len_lt2) begin
                        state_in = S_REV_READ;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INS_SHIFT: begin
            if (stat.cur_eq_pos) begin
               state_in = S_INS_LAST;
            end
         end
         S_INS_LAST:  state_in = S_INS_WRITE;
         S_INS_WRITE: state_in = S_RESULT;
         S_DEL_SHIFT: begin
            if (stat.cur_eq_len) begin
               state_in = S_DEL_LAST;
            end
         end
         S_DEL_LAST: state_in = S_RESULT;
         S_REV_READ: state_in = S_REV_WLO;
         S_REV_WLO:  state_in = S_REV_WHI;
         S_REV_WHI:  state_in = stat.rev_more ? S_REV_READ : S_IDLE;
         S_LIST_READ: state_in = S_LIST_SEND;
         S_LIST_SEND: begin
            if (stat.out_free) begin
               state_in = stat.cur_last ? S_IDLE : S_LIST_READ;
            end
         end
         S_RESULT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd            = '0;
      cmd.cur_op     = CUR_HOLD;
      cmd.hi_op      = HI_HOLD;
      cmd.len_op     = LEN_HOLD;
      cmd.wa_sel     = WA_CUR;
      cmd.wd_sel     = WD_RDA;
      cmd.out_status = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               unique case (req_data.func)
                  FUNC_INSERT: begin
                     cmd.cur_op = CUR_LEN_M1;
                     if (stat.ins_ok) begin
                        cmd.len_op = LEN_INC;
                     end
                  end
                  FUNC_DELETE: begin
                     cmd.cur_op = CUR_POS_P1;
                     if (stat.del_ok) begin
                        cmd.len_op = LEN_DEC;
                     end
                  end
                  FUNC_LIST: cmd.cur_op = CUR_ZERO;
                  FUNC_REVERSE: begin
                     cmd.cur_op = CUR_ZERO;
                     cmd.hi_op  = HI_LEN_M1;
                  end
                  default: cmd.cur_op = CUR_HOLD;
               endcase
            end
         end
         S_INS_SHIFT: begin
            cmd.rd_en  = 1'b1;
            cmd.wr_en  = !first_ff;
            cmd.wa_sel = WA_CUR_P2;
            cmd.wd_sel = WD_RDA;
            if (!stat.cur_eq_pos) begin
               cmd.cur_op = CUR_DEC;
            end
         end
         S_INS_LAST: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_CUR_P1;
            cmd.wd_sel = WD_RDA;
         end
         S_INS_WRITE: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_POS;
            cmd.wd_sel = WD_VAL;
         end
         S_DEL_SHIFT: begin
            cmd.rd_en  = 1'b1;
            cmd.wr_en  = !first_ff;
            cmd.wa_sel = WA_CUR_M2;
            cmd.wd_sel = WD_RDA;
            if (!stat.cur_eq_len) begin
               cmd.cur_op = CUR_INC;
            end
         end
         S_DEL_LAST: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_CUR_M1;
            cmd.wd_sel = WD_RDA;
         end
         S_REV_READ: cmd.rd_en = 1'b1;
         S_REV_WLO: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_CUR;
            cmd.wd_sel = WD_RDB;
         end
         S_REV_WHI: begin
            cmd.wr_en  = 1'b1;
            cmd.wa_sel = WA_HI;
            cmd.wd_sel = WD_RDA;
            cmd.cur_op = CUR_INC;
            cmd.hi_op  = HI_DEC;
         end
         S_LIST_READ: cmd.rd_en = 1'b1;
         S_LIST_SEND: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_ITEM;
               if (!stat.cur_last) begin
                  cmd.cur_op = CUR_INC;
               end
            end
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = ok_ff ? ST_OK : ST_FAIL;
            end
         end
         default: cmd.rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         first_ff <= 1'b0;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         ok_ff    <= ok_in;
      end
   end

endmodule
